>>> design/iofp_pkg.sv
// ----------------------------------------------------------------------------
// iofp_pkg
// Shared types and constants for the orientation frame parser.
// ----------------------------------------------------------------------------
package iofp_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hAA;

  typedef logic [4:0] pos_t;

  localparam pos_t FIRST_BODY_POS = 5'd2;
  localparam pos_t YAW_LO_POS     = 5'd3;
  localparam pos_t YAW_HI_POS     = 5'd4;
  localparam pos_t PITCH_LO_POS   = 5'd5;
  localparam pos_t PITCH_HI_POS   = 5'd6;
  localparam pos_t ROLL_LO_POS    = 5'd7;
  localparam pos_t ROLL_HI_POS    = 5'd8;
  localparam pos_t SUM_POS        = 5'd18;

  localparam logic [11:0] YAW_WRAP    = 12'd3600;
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef enum logic [1:0] {
    PH_SEEK1,
    PH_SEEK2,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  sum;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
  } frame_rec_t;

  // magnitude / 10 for magnitudes up to 32768
  function automatic logic [12:0] div10_mag(input logic [15:0] mag);
    logic [31:0] prod;
    prod = 32'(mag) * 32'(DIV10_MUL);
    return prod[31:DIV10_SHIFT];
  endfunction

endpackage

>>> design/imu_orientation_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_orientation_frame_parser
// Byte-serial orientation frame parser: header search, checksum, and
// conversion of yaw, pitch and roll to tenths of a degree.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | rx_byte
//  out     | out_valid | out_stall | frame_status, yaw_hundredths, yaw_tenths,
//          |           |           | pitch_tenths, roll_tenths, computed_sum
//
//  One byte per cycle while in_stall is low. A frame's record is written to
//  the queue as its checksum byte is taken, then passes the sign/magnitude
//  stage and then the divide stage before its result appears.
//  in_stall rises only while the record queue is full.
//  Synchronous reset clears the parse state, the queue and both stage valids.
// ----------------------------------------------------------------------------
module imu_orientation_frame_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               frame_status,
  output logic signed [15:0] yaw_hundredths,
  output logic [11:0]        yaw_tenths,
  output logic signed [12:0] pitch_tenths,
  output logic signed [12:0] roll_tenths,
  output logic [7:0]         computed_sum
);
  import iofp_pkg::*;

  logic       push_valid;
  frame_rec_t push_data;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  frame_rec_t q_data;

  iofp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  iofp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  iofp_convert u_convert (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_status   (frame_status),
    .yaw_hundredths (yaw_hundredths),
    .yaw_tenths     (yaw_tenths),
    .pitch_tenths   (pitch_tenths),
    .roll_tenths    (roll_tenths),
    .computed_sum   (computed_sum)
  );

endmodule

>>> design/iofp_parser.sv
// ----------------------------------------------------------------------------
// iofp_parser
// Header search, body byte collection and checksum; pushes one record per frame.
// ----------------------------------------------------------------------------
module iofp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               q_full,
  output logic               push_valid,
  output iofp_pkg::frame_rec_t push_data
);
  import iofp_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  pos_t        pos;
  logic [7:0]  sum;
  logic [15:0] yaw_word;
  logic [15:0] pitch_word;
  logic [15:0] roll_word;
  logic        accept;
  logic        in_body;
  logic        is_hdr;
  logic        frame_end;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign in_body  = pos < SUM_POS;
  assign is_hdr   = rx_byte == HDR_BYTE;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SEEK1: phase_next = is_hdr ? PH_SEEK2 : PH_SEEK1;
      PH_SEEK2: phase_next = is_hdr ? PH_BODY : PH_SEEK1;
      PH_BODY:  phase_next = in_body ? PH_BODY : PH_SEEK1;
      default:  phase_next = is_hdr ? PH_SEEK2 : PH_SEEK1;
    endcase
  end

  always_comb begin
    frame_end = (phase == PH_BODY) && !in_body;
    push_valid = accept && frame_end;
    push_data.status = sum != rx_byte;
    push_data.sum    = sum;
    push_data.yaw    = yaw_word;
    push_data.pitch  = pitch_word;
    push_data.roll   = roll_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEEK1;
      pos   <= '0;
      sum   <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (phase == PH_SEEK2 && is_hdr) begin
        pos <= FIRST_BODY_POS;
        sum <= '0;
      end else if (phase == PH_BODY) begin
        if (in_body) begin
          pos <= pos + 5'd1;
          sum <= sum + rx_byte;
        end else begin
          pos <= '0;
          sum <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_BODY) begin
      case (pos)
        YAW_LO_POS:   yaw_word[7:0]    <= rx_byte;
        YAW_HI_POS:   yaw_word[15:8]   <= rx_byte;
        PITCH_LO_POS: pitch_word[7:0]  <= rx_byte;
        PITCH_HI_POS: pitch_word[15:8] <= rx_byte;
        ROLL_LO_POS:  roll_word[7:0]   <= rx_byte;
        ROLL_HI_POS:  roll_word[15:8]  <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule

>>> design/iofp_queue.sv
// ----------------------------------------------------------------------------
// iofp_queue
// Short FIFO of frame records between parser and converter.
// ----------------------------------------------------------------------------
module iofp_queue #(
  parameter int Depth = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  iofp_pkg::frame_rec_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output iofp_pkg::frame_rec_t pop_data
);
  import iofp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  frame_rec_t      entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full     = count == CntW'(Depth);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/iofp_convert.sv
// ----------------------------------------------------------------------------
// iofp_convert
// Two-stage conversion of a frame record to tenths of a degree.
// ----------------------------------------------------------------------------
module iofp_convert (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  iofp_pkg::frame_rec_t q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 frame_status,
  output logic signed [15:0]   yaw_hundredths,
  output logic [11:0]          yaw_tenths,
  output logic signed [12:0]   pitch_tenths,
  output logic signed [12:0]   roll_tenths,
  output logic [7:0]           computed_sum
);
  import iofp_pkg::*;

  // stage A: sign and magnitude
  logic        a_valid;
  logic        a_status;
  logic [7:0]  a_sum;
  logic [15:0] a_yaw_raw;
  logic [15:0] a_yaw_mag;
  logic [15:0] a_pitch_mag;
  logic [15:0] a_roll_mag;
  logic        a_yaw_neg;
  logic        a_pitch_neg;
  logic        a_roll_neg;

  logic        a_ready;
  logic        b_ready;
  logic [12:0] yaw_q;
  logic [12:0] pitch_q;
  logic [12:0] roll_q;

  assign b_ready = !out_valid || !out_stall;
  assign a_ready = !a_valid || b_ready;
  assign q_pop   = !q_empty && a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_status    <= q_data.status;
      a_sum       <= q_data.sum;
      a_yaw_raw   <= q_data.yaw;
      a_yaw_neg   <= q_data.yaw[15];
      a_pitch_neg <= q_data.pitch[15];
      a_roll_neg  <= q_data.roll[15];
      a_yaw_mag   <= q_data.yaw[15] ? 16'(-q_data.yaw) : q_data.yaw;
      a_pitch_mag <= q_data.pitch[15] ? 16'(-q_data.pitch) : q_data.pitch;
      a_roll_mag  <= q_data.roll[15] ? 16'(-q_data.roll) : q_data.roll;
    end
  end

  assign yaw_q   = div10_mag(a_yaw_mag);
  assign pitch_q = div10_mag(a_pitch_mag);
  assign roll_q  = div10_mag(a_roll_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      frame_status   <= a_status;
      computed_sum   <= a_sum;
      yaw_hundredths <= a_yaw_raw;
      yaw_tenths     <= (a_yaw_neg && yaw_q != '0) ? YAW_WRAP - yaw_q[11:0] : yaw_q[11:0];
      pitch_tenths   <= a_pitch_neg ? -pitch_q : pitch_q;
      roll_tenths    <= a_roll_neg ? -roll_q : roll_q;
    end
  end

endmodule

>>> design/iofp_checker.sv
// ----------------------------------------------------------------------------
// iofp_checker
// Port-level checks for the orientation frame parser.
// ----------------------------------------------------------------------------
module iofp_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic               frame_status,
  input logic signed [15:0] yaw_hundredths,
  input logic [11:0]        yaw_tenths,
  input logic signed [12:0] pitch_tenths,
  input logic signed [12:0] roll_tenths,
  input logic [7:0]         computed_sum
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_status) && $stable(yaw_hundredths)
      && $stable(yaw_tenths) && $stable(pitch_tenths) && $stable(roll_tenths)
      && $stable(computed_sum))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> yaw_tenths <= 12'd3599)
    else $error("yaw tenths out of range");

  a_pr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pitch_tenths <= 13'sd3276 && pitch_tenths >= -13'sd3276
      && roll_tenths <= 13'sd3276 && roll_tenths >= -13'sd3276)
    else $error("pitch or roll tenths out of range");

  a_yaw_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !yaw_hundredths[15] |->
      (17'(yaw_tenths) * 17'd10 <= 17'(yaw_hundredths[14:0]))
      && (17'(yaw_tenths) * 17'd10 + 17'd10 > 17'(yaw_hundredths[14:0])))
    else $error("yaw tenths disagree with raw yaw");

endmodule

bind imu_orientation_frame_parser iofp_checker u_iofp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .frame_status   (frame_status),
  .yaw_hundredths (yaw_hundredths),
  .yaw_tenths     (yaw_tenths),
  .pitch_tenths   (pitch_tenths),
  .roll_tenths    (roll_tenths),
  .computed_sum   (computed_sum)
);

>>> verif/frame_parser_checker.sv
// ----------------------------------------------------------------------------
// frame_parser_checker
// Watches both channels of the orientation frame parser. Decodes the
// accepted serial bytes with its own header hunt, body collection and
// checksum, queues the decoded frames and compares every accepted result
// field by field with the oldest queued frame.
// ----------------------------------------------------------------------------
module frame_parser_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               frame_status,
  input  logic signed [15:0] yaw_hundredths,
  input  logic [11:0]        yaw_tenths,
  input  logic signed [12:0] pitch_tenths,
  input  logic signed [12:0] roll_tenths,
  input  logic [7:0]         computed_sum,
  output int                 mismatch_count,
  output int                 frames_outstanding
);
  import iofp_pkg::*;

  localparam int TENTHS_DIV = 10;

  typedef struct {
    logic               status;
    logic signed [15:0] yaw_raw;
    logic [11:0]        yaw_t;
    logic signed [12:0] pitch_t;
    logic signed [12:0] roll_t;
    logic [7:0]         sum;
  } orientation_t;

  orientation_t frames_expected [$];

  phase_t      hunt_phase;
  pos_t        body_pos;
  logic [7:0]  body_sum;
  logic [15:0] yaw_acc;
  logic [15:0] pitch_acc;
  logic [15:0] roll_acc;

  // signed truncation toward zero
  function automatic logic signed [12:0] angle_tenths(input logic [15:0] w);
    int v;
    v = int'($signed(w));
    v = v / TENTHS_DIV;
    return v[12:0];
  endfunction

  function automatic logic [11:0] heading_tenths(input logic [15:0] w);
    int v;
    v = int'($signed(w));
    v = v / TENTHS_DIV;
    if (v < 0) begin
      v += int'(YAW_WRAP);
    end
    return v[11:0];
  endfunction

  task automatic absorb_rx_byte(input logic [7:0] b);
    orientation_t f;
    case (hunt_phase)
      PH_SEEK2: begin
        if (b == HDR_BYTE) begin
          hunt_phase = PH_BODY;
          body_pos   = FIRST_BODY_POS;
          body_sum   = '0;
        end else begin
          hunt_phase = PH_SEEK1;
        end
      end
      PH_BODY: begin
        if (body_pos < SUM_POS) begin
          body_sum += b;
          case (body_pos)
            YAW_LO_POS:   yaw_acc[7:0]    = b;
            YAW_HI_POS:   yaw_acc[15:8]   = b;
            PITCH_LO_POS: pitch_acc[7:0]  = b;
            PITCH_HI_POS: pitch_acc[15:8] = b;
            ROLL_LO_POS:  roll_acc[7:0]   = b;
            ROLL_HI_POS:  roll_acc[15:8]  = b;
            default: ;
          endcase
          body_pos++;
        end else begin
          f.status  = (b != body_sum);
          f.yaw_raw = yaw_acc;
          f.yaw_t   = heading_tenths(yaw_acc);
          f.pitch_t = angle_tenths(pitch_acc);
          f.roll_t  = angle_tenths(roll_acc);
          f.sum     = body_sum;
          frames_expected.push_back(f);
          hunt_phase = PH_SEEK1;
          body_pos   = '0;
          body_sum   = '0;
        end
      end
      default: begin
        if (b == HDR_BYTE) begin
          hunt_phase = PH_SEEK2;
        end else begin
          hunt_phase = PH_SEEK1;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  task automatic check_frame();
    orientation_t e;
    if (frames_expected.size() == 0) begin
      $error("orientation result with no frame pending");
      mismatch_count++;
      return;
    end
    e = frames_expected.pop_front();
    compare_field("frame_status", 32'(e.status), 32'(frame_status));
    compare_field("yaw_hundredths", 32'(e.yaw_raw), 32'(yaw_hundredths));
    compare_field("yaw_tenths", 32'(e.yaw_t), 32'(yaw_tenths));
    compare_field("pitch_tenths", 32'(e.pitch_t), 32'(pitch_tenths));
    compare_field("roll_tenths", 32'(e.roll_t), 32'(roll_tenths));
    compare_field("computed_sum", 32'(e.sum), 32'(computed_sum));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hunt_phase = PH_SEEK1;
      body_pos   = '0;
      body_sum   = '0;
      yaw_acc    = '0;
      pitch_acc  = '0;
      roll_acc   = '0;
      frames_expected.delete();
      mismatch_count     = 0;
      frames_outstanding = 0;
    end else begin
      // a frame finished at this edge cannot leave at this edge: compare first
      if (out_valid && !out_stall) begin
        check_frame();
      end
      if (in_valid && !in_stall) begin
        absorb_rx_byte(rx_byte);
      end
      frames_outstanding = frames_expected.size();
    end
  end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds the orientation frame parser a byte stream of directed and random
// frames (good and bad checksums, extreme angles, header bytes inside the
// body, broken headers, cut frames and noise) with random gaps on the input
// and random stalls on the output, including one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import iofp_pkg::*;

  localparam int STREAM_TARGET  = 650;
  localparam int IDLE_LIMIT     = 10000;
  localparam int LONG_HOLD      = 1500;
  localparam int HOLD_AT_RESULT = 6;
  localparam int DRAIN_CYCLES   = 20;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic out_stall = 1'b0;

  logic               in_stall;
  logic               out_valid;
  logic               frame_status;
  logic signed [15:0] yaw_hundredths;
  logic [11:0]        yaw_tenths;
  logic signed [12:0] pitch_tenths;
  logic signed [12:0] roll_tenths;
  logic [7:0]         computed_sum;

  int mismatch_count;
  int frames_outstanding;

  logic [7:0] rx_stream [$];

  always #5 clk = ~clk;

  imu_orientation_frame_parser u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_status   (frame_status),
    .yaw_hundredths (yaw_hundredths),
    .yaw_tenths     (yaw_tenths),
    .pitch_tenths   (pitch_tenths),
    .roll_tenths    (roll_tenths),
    .computed_sum   (computed_sum)
  );

  frame_parser_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .rx_byte            (rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .frame_status       (frame_status),
    .yaw_hundredths     (yaw_hundredths),
    .yaw_tenths         (yaw_tenths),
    .pitch_tenths       (pitch_tenths),
    .roll_tenths        (roll_tenths),
    .computed_sum       (computed_sum),
    .mismatch_count     (mismatch_count),
    .frames_outstanding (frames_outstanding)
  );

  function automatic logic [7:0] body_byte();
    if ($urandom_range(0, 7) == 0) begin
      return HDR_BYTE;
    end
    return 8'($urandom());
  endfunction

  // angle words biased toward the extremes and the truncation corners
  function automatic logic [15:0] pick_word();
    int mag;
    mag = $urandom_range(0, 40);
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4, 5:    return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void append_frame(input logic [7:0] idx, input logic [15:0] yaw,
                                       input logic [15:0] pitch, input logic [15:0] roll,
                                       input bit corrupt);
    logic [7:0] fb [int'(SUM_POS) + 1];
    logic [7:0] sum;
    sum = '0;
    fb[0] = HDR_BYTE;
    fb[1] = HDR_BYTE;
    for (int i = FIRST_BODY_POS + 1; i < SUM_POS; i++) begin
      fb[i] = body_byte();
    end
    fb[FIRST_BODY_POS] = idx;
    fb[YAW_LO_POS]     = yaw[7:0];
    fb[YAW_HI_POS]     = yaw[15:8];
    fb[PITCH_LO_POS]   = pitch[7:0];
    fb[PITCH_HI_POS]   = pitch[15:8];
    fb[ROLL_LO_POS]    = roll[7:0];
    fb[ROLL_HI_POS]    = roll[15:8];
    for (int i = FIRST_BODY_POS; i < SUM_POS; i++) begin
      sum += fb[i];
    end
    fb[SUM_POS] = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
    foreach (fb[i]) begin
      rx_stream.push_back(fb[i]);
    end
  endfunction

  // byte source, then drain and verdict
  initial begin
    int gap;
    int burst_left;
    int cut;
    logic [7:0] stray;

    // directed: noise, broken header, header byte as index with extreme angles
    // and a bad checksum, then clean frames around the yaw wrap
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(HDR_BYTE);
    rx_stream.push_back(~HDR_BYTE);
    append_frame(HDR_BYTE, 16'h8000, 16'h7FFF, 16'h8000, 1'b1);
    append_frame(8'h00, 16'hFFF6, 16'h8000, 16'h7FFF, 1'b0);
    append_frame(8'hFF, 16'hFFF7, 16'hFFFF, 16'h0000, 1'b0);

    while (rx_stream.size() < STREAM_TARGET) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          repeat ($urandom_range(1, 6)) rx_stream.push_back(body_byte());
        end
        2: begin
          stray = 8'($urandom());
          if (stray == HDR_BYTE) begin
            stray = ~HDR_BYTE;
          end
          rx_stream.push_back(HDR_BYTE);
          rx_stream.push_back(stray);
        end
        3: begin
          append_frame(8'($urandom()), pick_word(), pick_word(), pick_word(), 1'b0);
          cut = $urandom_range(1, 15);
          repeat (cut) void'(rx_stream.pop_back());
        end
        default: begin
          append_frame(8'($urandom()), pick_word(), pick_word(), pick_word(),
                       $urandom_range(0, 6) == 0);
        end
      endcase
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    burst_left = 0;
    foreach (rx_stream[k]) begin
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 15) == 0) begin
          burst_left = $urandom_range(10, 60);
        end
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      rx_byte  <= rx_stream[k];
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (frames_outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && frames_outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result sink; one long hold-off lets the parser back up into its input
  initial begin
    int hold;
    int burst_left;
    int taken;
    burst_left = 0;
    taken      = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT_RESULT) begin
        hold = LONG_HOLD;
      end else if (burst_left > 0) begin
        hold = 0;
        burst_left--;
      end else begin
        hold = $urandom_range(0, 10);
        if ($urandom_range(0, 7) == 0) begin
          burst_left = $urandom_range(3, 15);
        end
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= IDLE_LIMIT) begin
        $error("no item moved for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

>>> imu_orientation_frame_parser.f
design/iofp_pkg.sv
design/iofp_parser.sv
design/iofp_queue.sv
design/iofp_convert.sv
design/imu_orientation_frame_parser.sv
design/iofp_checker.sv
verif/frame_parser_checker.sv
verif/testbench.sv
